/* rtl/frjw_pkg.sv */
// Shared types and constants of the filament runout and jam watchdog.
`timescale 1ns / 1ps
package frjw_pkg;

	localparam int unsigned GRACE_MS_W = 14;
	localparam int unsigned CHECK_MS_W = 7;
	localparam int unsigned SINCE_W    = 17;
	localparam int unsigned POS_EL_W   = 16;

	localparam logic [GRACE_MS_W-1:0] GRACE_MS  = 14'd10000;
	localparam logic [CHECK_MS_W-1:0] CHECK_MS  = 7'd100;
	localparam logic [CHECK_MS_W-1:0] CHECK_MAX = '1;
	localparam logic [15:0]           EARLY_LAYER_MAX = 16'd3;

	localparam logic [15:0] TIMEOUT_RESET   = 16'd2000;
	localparam logic [15:0] POS_CHECK_RESET = 16'd1000;

	typedef enum logic [1:0] {
		CFG_MOTION_TIMEOUT = 2'd0,
		CFG_AUTO_PAUSE     = 2'd1,
		CFG_DIRECT_MODE    = 2'd2,
		CFG_POSITION_CHECK = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_RUNOUT = 2'd1,
		EV_JAM    = 2'd2
	} event_t;

	typedef struct packed {
		logic [15:0] motion_timeout_ms;
		logic        auto_pause;
		logic        direct_mode;
		logic [15:0] position_check_ms;
	} cfg_t;

	typedef struct packed {
		logic [31:0] head_position;
		logic [15:0] total_layers;
		logic [15:0] current_layer;
		logic        printing;
		logic        motion_pulse;
		logic        filament_present;
	} item_t;

	typedef struct packed {
		logic   pause_request;
		event_t event_code;
		logic   error_active;
		logic   runout_level;
	} result_t;

endpackage

/* rtl/filament_runout_jam_watchdog.sv */
// Top level of the filament runout and jam watchdog.
// An accepted item is held in the input register, and its result in the result register.
// Throughput: one item per cycle; input and result registers advance together
// whenever the result slot is empty or being taken.
// Reset (arst_n low, asynchronous): 2000 ms timeout, auto pause and direct mode on,
// 1000 ms position interval; state clears with both checks due, stored position undefined.
`timescale 1ns / 1ps
module filament_runout_jam_watchdog (
	input  logic                clk,
	input  logic                arst_n,
	// input items, one per millisecond tick
	input  logic                s_tvalid,
	output logic                s_tready,
	// [0] filament_present, [1] motion_pulse, [2] printing,
	// [18:3] current_layer, [34:19] total_layers, [66:35] head_position, rest zero
	input  logic [71:0]         s_tdata,
	// result items
	output logic                m_tvalid,
	input  logic                m_tready,
	// [0] runout_level, [1] error_active, [3:2] event_code, [4] pause_request,
	// rest zero
	output logic [7:0]          m_tdata,
	// configuration writes
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  frjw_pkg::cfg_idx_t  cfg_index,
	input  logic [15:0]         cfg_data
);
	import frjw_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t result;
	result_t result_s2;
	logic    valid_s2;
	logic    out_free;
	logic    fire;

	// Writes are always taken; the register file updates at the next clock edge.
	assign cfg_ready = 1'b1;

	frjw_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_valid),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	// The result slot frees up when empty or when its item leaves this cycle.
	assign out_free = !valid_s2 || m_tready;
	// Process the held input item only when its result has somewhere to go.
	assign fire     = valid_s1 && out_free;
	// Take a new item whenever the input register empties or moves on.
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (out_free)
				valid_s2 <= valid_s1;
		end
	end

	// Capture the incoming item; only the defined low bits carry fields.
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			item_s1 <= item_t'(s_tdata[$bits(item_t)-1:0]);
		if (fire)
			result_s2 <= result;
	end

	frjw_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.cfg    (cfg),
		.item   (item_s1),
		.result (result)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(8 - $bits(result_t)){1'b0}}, result_s2};

endmodule

/* rtl/frjw_cfg.sv */
// Configuration register file of the filament watchdog.
`timescale 1ns / 1ps
module frjw_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  frjw_pkg::cfg_idx_t index,
	input  logic [15:0]       data,
	output frjw_pkg::cfg_t    cfg
);
	import frjw_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.motion_timeout_ms <= TIMEOUT_RESET;
			cfg_q.auto_pause        <= 1'b1;
			cfg_q.direct_mode       <= 1'b1;
			cfg_q.position_check_ms <= POS_CHECK_RESET;
		end else if (wr_en) begin
			case (index)
				CFG_MOTION_TIMEOUT: cfg_q.motion_timeout_ms <= data;
				CFG_AUTO_PAUSE:     cfg_q.auto_pause        <= data[0];
				CFG_DIRECT_MODE:    cfg_q.direct_mode       <= data[0];
				CFG_POSITION_CHECK: cfg_q.position_check_ms <= data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/frjw_core.sv */
// Watchdog state registers and the per-tick update logic.
`timescale 1ns / 1ps
module frjw_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  frjw_pkg::cfg_t    cfg,
	input  frjw_pkg::item_t   item,
	output frjw_pkg::result_t result
);
	import frjw_pkg::*;

	logic                  pend_q, pend_n;
	logic [SINCE_W-1:0]    since_q, since_n;
	logic                  err_q, err_n;
	logic                  seen_q, seen_n;
	logic                  gstart_q, gstart_n;
	logic [GRACE_MS_W-1:0] gel_q, gel_n;
	logic [CHECK_MS_W-1:0] chk_q, chk_n;
	logic [POS_EL_W-1:0]   pel_q, pel_n;
	logic [31:0]           lastpos_q, lastpos_n;
	logic                  pvalid_q, pvalid_n;

	logic                  done;
	logic [SINCE_W-1:0]    since_v;
	logic [SINCE_W-1:0]    limit;
	logic                  last_layer;
	logic                  moving;
	logic                  early;
	event_t                ev;
	logic                  pause;

	always_comb begin
		// advance every elapsed counter, saturating at all ones
		since_n   = (since_q == '1) ? since_q : since_q + SINCE_W'(1);
		gel_n     = (gel_q == '1) ? gel_q : gel_q + GRACE_MS_W'(1);
		chk_n     = (chk_q == '1) ? chk_q : chk_q + CHECK_MS_W'(1);
		pel_n     = (pel_q == '1) ? pel_q : pel_q + POS_EL_W'(1);
		pend_n    = pend_q;
		err_n     = err_q;
		seen_n    = seen_q;
		gstart_n  = gstart_q;
		lastpos_n = lastpos_q;
		pvalid_n  = pvalid_q;
		done      = 1'b0;
		since_v   = '0;
		limit     = '0;
		last_layer = 1'b0;
		moving    = 1'b0;
		early     = 1'b0;
		ev        = EV_NONE;
		pause     = 1'b0;

		if (item.motion_pulse) begin
			since_n = '0;
			pend_n  = 1'b1;
		end

		if (!item.printing) begin
			err_n  = 1'b0;
			chk_n  = CHECK_MAX;
			seen_n = 1'b0;
			done   = 1'b1;
		end else if (item.current_layer == '0) begin
			err_n    = 1'b0;
			gstart_n = 1'b0;
			done     = 1'b1;
		end

		// grace period starts on the first printed tick of layer one
		if (!done) begin
			if (item.current_layer == 16'd1 && !gstart_n) begin
				gstart_n = 1'b1;
				gel_n    = '0;
				since_n  = '0;
			end
			if (gstart_n && gel_n < GRACE_MS)
				done = 1'b1;
		end

		if (!done) begin
			if (!item.filament_present && !err_n) begin
				err_n = 1'b1;
				ev    = EV_RUNOUT;
				pause = !cfg.direct_mode && cfg.auto_pause;
				done  = 1'b1;
			end else if (item.filament_present && err_n) begin
				err_n = 1'b0;
			end
		end

		if (!done && chk_n < CHECK_MS)
			done = 1'b1;

		if (!done) begin
			chk_n   = '0;
			since_v = since_n;
			if (pend_n) begin
				pend_n = 1'b0;
				seen_n = 1'b1;
				err_n  = 1'b0;
			end
			last_layer = (item.total_layers != '0) &&
				(item.current_layer >= item.total_layers);
			// head position compare; the first one only stores the word
			if (pel_n >= cfg.position_check_ms) begin
				pel_n     = '0;
				moving    = pvalid_n && (item.head_position != lastpos_q);
				lastpos_n = item.head_position;
				pvalid_n  = 1'b1;
			end
			early = (item.current_layer <= EARLY_LAYER_MAX);
			limit = early ? {cfg.motion_timeout_ms, 1'b0} : {1'b0, cfg.motion_timeout_ms};
			if (moving && !last_layer) begin
				if ((seen_n || early) && since_v > limit && !err_n) begin
					err_n = 1'b1;
					ev    = EV_JAM;
					pause = cfg.auto_pause;
				end
			end else if (last_layer && err_n) begin
				err_n = 1'b0;
			end
		end

		result.runout_level  = cfg.direct_mode ? item.filament_present : 1'b1;
		result.error_active  = err_n;
		result.event_code    = ev;
		result.pause_request = pause;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q   <= 1'b0;
			since_q  <= '0;
			err_q    <= 1'b0;
			seen_q   <= 1'b0;
			gstart_q <= 1'b0;
			gel_q    <= '0;
			chk_q    <= CHECK_MS;
			pel_q    <= '1;
			pvalid_q <= 1'b0;
		end else if (fire) begin
			pend_q   <= pend_n;
			since_q  <= since_n;
			err_q    <= err_n;
			seen_q   <= seen_n;
			gstart_q <= gstart_n;
			gel_q    <= gel_n;
			chk_q    <= chk_n;
			pel_q    <= pel_n;
			pvalid_q <= pvalid_n;
		end
	end

	// last position is guarded by its valid bit and needs no reset
	always_ff @(posedge clk) begin
		if (fire)
			lastpos_q <= lastpos_n;
	end

endmodule

/* test/filament_runout_jam_watchdog_tb.sv */
// Self-checking testbench of the filament runout and jam watchdog.
`timescale 1ns / 1ps
module filament_runout_jam_watchdog_tb;
	import frjw_pkg::*;

	// cycles the receiver holds off in one stretch to back the block up
	localparam int LONG_HOLD = 400;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	// [0] filament_present, [1] motion_pulse, [2] printing,
	// [18:3] current_layer, [34:19] total_layers, [66:35] head_position, rest zero
	logic [71:0] s_tdata   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	// [0] runout_level, [1] error_active, [3:2] event_code, [4] pause_request, rest zero
	logic [7:0]  m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	cfg_idx_t    cfg_index = CFG_MOTION_TIMEOUT;
	logic [15:0] cfg_data  = '0;

	filament_runout_jam_watchdog dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// One row of the directed table: either a register write or a tick.
	// Rows with a typed status carry their answer; the rest go through the model.
	typedef struct {
		bit          is_cfg;
		cfg_idx_t    idx;
		logic [15:0] data;
		item_t       it;
		bit          typed;
		result_t     want;
	} plan_row_t;

	plan_row_t plan [24];

	// model copy of the registers
	logic [15:0] cfg_timeout;
	logic        cfg_auto;
	logic        cfg_direct;
	logic [15:0] cfg_pos_ms;

	// model copy of the watchdog state
	logic        pend_pulse;
	logic [16:0] since_pulse;
	logic        err_flag;
	logic        seen_motion;
	logic        grace_on;
	logic [13:0] grace_cnt;
	logic [6:0]  check_cnt;
	logic [15:0] pos_cnt;
	logic [31:0] prev_pos;
	logic        prev_pos_ok;

	// status words still owed by the block, oldest first
	result_t status_due [$];

	int fails        = 0;
	int ticks_sent   = 0;
	int status_seen  = 0;
	int runouts_due  = 0;
	int jams_due     = 0;
	int pauses_due   = 0;
	int settings_run = 0;

	// idle rates in percent of cycles, and the long-hold request handshake
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int stall_asked   = 0;
	int stall_served  = 0;
	int hold_left     = 0;

	// random stimulus state: sticky layer, job size and head word
	logic [15:0] gen_layer = 16'd2;
	logic [15:0] gen_total = 16'd0;
	logic [31:0] gen_pos   = '0;
	int          pulse_pct = 0;
	int          seg_left  = 0;

	function automatic result_t res(input logic rl, input logic er, input event_t ev,
		input logic pr);
		result_t r;
		r.runout_level  = rl;
		r.error_active  = er;
		r.event_code    = ev;
		r.pause_request = pr;
		return r;
	endfunction

	function automatic plan_row_t tick_row(input logic pres, input logic pul, input logic prn,
		input logic [15:0] layer, input logic [15:0] total, input logic [31:0] pos,
		input bit typed, input result_t want);
		plan_row_t row;
		row.is_cfg              = 1'b0;
		row.idx                 = CFG_MOTION_TIMEOUT;
		row.data                = '0;
		row.it.filament_present = pres;
		row.it.motion_pulse     = pul;
		row.it.printing         = prn;
		row.it.current_layer    = layer;
		row.it.total_layers     = total;
		row.it.head_position    = pos;
		row.typed               = typed;
		row.want                = want;
		return row;
	endfunction

	function automatic plan_row_t cfg_row(input cfg_idx_t idx, input logic [15:0] val);
		plan_row_t row;
		row        = tick_row(1'b0, 1'b0, 1'b0, '0, '0, '0, 1'b0, '0);
		row.is_cfg = 1'b1;
		row.idx    = idx;
		row.data   = val;
		return row;
	endfunction

	// Advance the model by one millisecond tick and return the status it owes.
	function automatic result_t tick_status(input item_t it);
		logic [16:0] since;
		logic [17:0] limit;
		logic        last_layer;
		logic        moving;
		logic        early;
		event_t      ev;
		logic        pause;
		result_t     r;
		ev    = EV_NONE;
		pause = 1'b0;
		// every elapsed counter advances first and sticks at all ones
		if (since_pulse != '1) since_pulse++;
		if (grace_cnt != '1) grace_cnt++;
		if (check_cnt != '1) check_cnt++;
		if (pos_cnt != '1) pos_cnt++;
		if (it.motion_pulse) begin
			since_pulse = '0;
			pend_pulse  = 1'b1;
		end
		if (!it.printing) begin
			// idle printer: drop the error, make the next check due at once
			err_flag    = 1'b0;
			check_cnt   = CHECK_MAX;
			seen_motion = 1'b0;
		end else if (it.current_layer == 16'd0) begin
			err_flag = 1'b0;
			grace_on = 1'b0;
		end else begin
			if (it.current_layer == 16'd1 && !grace_on) begin
				grace_on    = 1'b1;
				grace_cnt   = '0;
				since_pulse = '0;
			end
			if (!(grace_on && grace_cnt < GRACE_MS)) begin
				if (!it.filament_present && !err_flag) begin
					err_flag = 1'b1;
					ev       = EV_RUNOUT;
					pause    = !cfg_direct && cfg_auto;
				end else begin
					if (it.filament_present && err_flag) err_flag = 1'b0;
					if (check_cnt >= CHECK_MS) begin
						check_cnt = '0;
						since     = since_pulse;
						if (pend_pulse) begin
							pend_pulse  = 1'b0;
							seen_motion = 1'b1;
							err_flag    = 1'b0;
						end
						last_layer = it.total_layers != 16'd0 &&
							it.current_layer >= it.total_layers;
						// head compare only when its own interval is due
						moving = 1'b0;
						if (pos_cnt >= cfg_pos_ms) begin
							pos_cnt     = '0;
							moving      = prev_pos_ok && it.head_position != prev_pos;
							prev_pos    = it.head_position;
							prev_pos_ok = 1'b1;
						end
						if (moving && !last_layer) begin
							early = it.current_layer <= EARLY_LAYER_MAX;
							limit = early ? {1'b0, cfg_timeout, 1'b0} : {2'b00, cfg_timeout};
							if ((seen_motion || early) && {1'b0, since} > limit && !err_flag) begin
								err_flag = 1'b1;
								ev       = EV_JAM;
								pause    = cfg_auto;
							end
						end else if (last_layer && err_flag) begin
							err_flag = 1'b0;
						end
					end
				end
			end
		end
		r.runout_level  = cfg_direct ? it.filament_present : 1'b1;
		r.error_active  = err_flag;
		r.event_code    = ev;
		r.pause_request = pause;
		return r;
	endfunction

	task automatic note_mismatch(input string what, input int got_v, input int want_v);
		$display("mismatch at %0t ns, status %0d: %s got %0d want %0d",
			$time, status_seen, what, got_v, want_v);
		fails++;
	endtask

	// Offer one tick after a random gap; on acceptance queue the owed status.
	task automatic send_tick(input item_t it, input bit typed, input result_t want);
		int      gap;
		result_t model;
		gap = 0;
		while ($urandom_range(0, 99) < send_idle_pct) gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'b00000, it};
		do @(posedge clk); while (!s_tready);
		// run the model even for typed rows so its state keeps step
		model = tick_status(it);
		if (typed) model = want;
		status_due.push_back(model);
		ticks_sent++;
		if (model.event_code == EV_RUNOUT) runouts_due++;
		if (model.event_code == EV_JAM) jams_due++;
		if (model.pause_request) pauses_due++;
	endtask

	// Stop offering and hold until every owed status has come back.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (status_due.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_MOTION_TIMEOUT: cfg_timeout = val;
			CFG_AUTO_PAUSE:     cfg_auto    = val[0];
			CFG_DIRECT_MODE:    cfg_direct  = val[0];
			CFG_POSITION_CHECK: cfg_pos_ms  = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Write all four registers once the block is idle; flags carry junk upper bits.
	task automatic apply_settings(input logic [15:0] timeout, input logic auto_p,
		input logic direct, input logic [15:0] pos_ms);
		drain();
		write_reg(CFG_MOTION_TIMEOUT, timeout);
		write_reg(CFG_AUTO_PAUSE, {15'($urandom), auto_p});
		write_reg(CFG_DIRECT_MODE, {15'($urandom), direct});
		write_reg(CFG_POSITION_CHECK, pos_ms);
		settings_run++;
	endtask

	// Random ticks: mostly a printing job with sticky layers and head words,
	// bursts and droughts of motion pulses, and some fully random noise.
	task automatic run_random(input int n);
		item_t it;
		int    roll;
		for (int i = 0; i < n; i++) begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(20, 60);
				case ($urandom_range(0, 2))
					0: pulse_pct = 0;
					1: pulse_pct = 3;
					default: pulse_pct = 35;
				endcase
			end
			seg_left--;
			roll = $urandom_range(0, 99);
			if (roll < 8) begin
				it = item_t'({$urandom, $urandom, 3'($urandom)});
			end else begin
				if ($urandom_range(0, 99) < 4) begin
					// layer 1 stays out: it would restart the long grace period
					case ($urandom_range(0, 9))
						0: gen_layer = 16'd0;
						1, 2, 3: gen_layer = 16'($urandom_range(2, 3));
						4: gen_layer = 16'hFFFF;
						default: gen_layer = 16'($urandom_range(4, 40));
					endcase
					case ($urandom_range(0, 3))
						0: gen_total = 16'd0;
						1: gen_total = gen_layer;
						2: gen_total = gen_layer - 16'd1;
						default: gen_total = gen_layer + 16'($urandom_range(1, 200));
					endcase
				end
				if ($urandom_range(0, 99) < 40)
					gen_pos = $urandom_range(0, 1) ? $urandom : gen_pos + 32'd1;
				it.filament_present = $urandom_range(0, 99) < 88;
				it.motion_pulse     = $urandom_range(0, 99) < pulse_pct;
				it.printing         = $urandom_range(0, 99) < 94;
				it.current_layer    = gen_layer;
				it.total_layers     = gen_total;
				it.head_position    = gen_pos;
			end
			send_tick(it, 1'b0, '0);
		end
	endtask

	// Receiver: check each taken status, then pick next cycle's ready.
	always @(posedge clk) begin : rx_side
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = result_t'(m_tdata[4:0]);
			status_seen++;
			if (status_due.size() == 0) begin
				note_mismatch("status with nothing owed", int'(m_tdata), 0);
			end else begin
				want = status_due.pop_front();
				if (got.runout_level !== want.runout_level)
					note_mismatch("runout_level", int'(got.runout_level), int'(want.runout_level));
				if (got.error_active !== want.error_active)
					note_mismatch("error_active", int'(got.error_active), int'(want.error_active));
				if (got.event_code !== want.event_code)
					note_mismatch("event_code", int'(got.event_code), int'(want.event_code));
				if (got.pause_request !== want.pause_request)
					note_mismatch("pause_request", int'(got.pause_request),
						int'(want.pause_request));
			end
		end
		// a requested long hold wins over the random idle pattern
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left = hold_left - 1;
		end else if (stall_served != stall_asked) begin
			stall_served = stall_asked;
			hold_left    = LONG_HOLD - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= $urandom_range(0, 99) >= recv_idle_pct;
		end
	end

	initial begin : stimulus
		// model state after reset: both checks due, no grace, registers at defaults
		cfg_timeout = TIMEOUT_RESET;
		cfg_auto    = 1'b1;
		cfg_direct  = 1'b1;
		cfg_pos_ms  = POS_CHECK_RESET;
		pend_pulse  = 1'b0;
		since_pulse = '0;
		err_flag    = 1'b0;
		seen_motion = 1'b0;
		grace_on    = 1'b0;
		grace_cnt   = '0;
		check_cnt   = CHECK_MS;
		pos_cnt     = '1;
		prev_pos    = '0;
		prev_pos_ok = 1'b0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: reset defaults, grace start and forget, runout with and
		// without pause, zero timeout and interval, early-layer jam, last layer.
		plan = '{
			tick_row(1, 0, 0, 16'd0, 16'd0, 32'd0, 1, res(1, 0, EV_NONE, 0)),
			tick_row(0, 1, 0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1, res(0, 0, EV_NONE, 0)),
			tick_row(0, 0, 1, 16'd0, 16'd0, 32'd0, 1, res(0, 0, EV_NONE, 0)),
			tick_row(0, 0, 1, 16'd1, 16'd100, 32'd0, 1, res(0, 0, EV_NONE, 0)),
			tick_row(1, 1, 1, 16'd1, 16'd100, 32'd5, 1, res(1, 0, EV_NONE, 0)),
			tick_row(1, 0, 1, 16'd0, 16'd100, 32'd5, 1, res(1, 0, EV_NONE, 0)),
			tick_row(0, 0, 1, 16'd5, 16'd0, 32'd7, 1, res(0, 1, EV_RUNOUT, 0)),
			tick_row(0, 1, 1, 16'd5, 16'd0, 32'd7, 0, '0),
			tick_row(0, 0, 1, 16'd5, 16'd0, 32'd7, 0, '0),
			tick_row(1, 0, 1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 0, '0),
			cfg_row(CFG_DIRECT_MODE, 16'd0),
			tick_row(0, 0, 0, 16'd0, 16'd0, 32'd0, 1, res(1, 0, EV_NONE, 0)),
			tick_row(0, 0, 1, 16'd6, 16'd0, 32'd9, 1, res(1, 1, EV_RUNOUT, 1)),
			cfg_row(CFG_AUTO_PAUSE, 16'd0),
			tick_row(0, 0, 0, 16'd0, 16'd0, 32'd0, 1, res(1, 0, EV_NONE, 0)),
			tick_row(0, 0, 1, 16'd6, 16'd0, 32'd9, 1, res(1, 1, EV_RUNOUT, 0)),
			cfg_row(CFG_MOTION_TIMEOUT, 16'd0),
			cfg_row(CFG_POSITION_CHECK, 16'd0),
			cfg_row(CFG_AUTO_PAUSE, 16'd1),
			tick_row(1, 0, 0, 16'd0, 16'd0, 32'd0, 0, '0),
			tick_row(1, 0, 1, 16'd2, 16'd0, 32'd0, 0, '0),
			tick_row(1, 0, 0, 16'd0, 16'd0, 32'd0, 0, '0),
			tick_row(1, 1, 1, 16'd3, 16'd3, 32'h0000_1234, 0, '0),
			tick_row(1, 0, 1, 16'd40, 16'd0, 32'hFFFF_FFFF, 0, '0)
		};
		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				drain();
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				send_tick(plan[i].it, plan[i].typed, plan[i].want);
			end
		end

		// Random stage one: sender idles lightly, receiver heavily.
		send_idle_pct = 22;
		recv_idle_pct = 71;
		apply_settings(16'd40, 1'b1, 1'b0, 16'd5);
		run_random(110);
		apply_settings(16'd0, 1'b0, 1'b0, 16'd0);
		run_random(110);

		// Random stage two: the other way round.
		send_idle_pct = 71;
		recv_idle_pct = 22;
		apply_settings(16'hFFFF, 1'b1, 1'b1, 16'hFFFF);
		run_random(110);
		apply_settings(16'd1, 1'b1, 1'b0, 16'd1);
		run_random(110);

		// Random stage three: no idling, but one long receiver hold first so the
		// block fills and pushes back on the sender.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		apply_settings(16'd150, 1'b0, 1'b1, 16'd30);
		stall_asked++;
		run_random(110);
		apply_settings(16'd20, 1'b1, 1'b0, 16'd2);
		run_random(110);

		// settle: anything arriving now is unowed and flagged by the receiver
		drain();
		repeat (8) @(posedge clk);
		if (status_due.size() != 0) note_mismatch("status still owed", status_due.size(), 0);

		$display("covered %0d ticks under %0d register settings, %0d statuses checked",
			ticks_sent, settings_run + 1, status_seen);
		$display("owed events: %0d runout, %0d jam, %0d pause requests; %0d mismatches",
			runouts_due, jams_due, pauses_due, fails);
		if (fails == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Watchdog on the run itself: end it if the block stops answering.
	initial begin : run_limit
		#3_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* filelist.f */
rtl/frjw_pkg.sv
rtl/frjw_cfg.sv
rtl/frjw_core.sv
rtl/filament_runout_jam_watchdog.sv
test/filament_runout_jam_watchdog_tb.sv
